// ----- hw/rtl/cdad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date add days package
// Shared widths, microcode encodings and calendar helper functions.
// ----------------------------------------------------------------------------
package cdad_pkg;

    localparam int YEAR_BITS_DEF = 16;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int ADD_W   = 16;
    localparam int REM_W   = 17;
    localparam int R400_W  = 9;
    localparam int PC_W    = 3;

    localparam int YEAR_EXT_W  = 32;
    localparam int FOLD_W      = 13;
    localparam int RECIP_W     = 16;
    localparam int PROD_W      = FOLD_W + RECIP_W;
    localparam int RECIP_SHIFT = 20;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;
    localparam int R25_W       = 5;

    localparam logic [FOLD_W-1:0]  W_BYTE1   = 13'd6;
    localparam logic [FOLD_W-1:0]  W_BYTE2   = 13'd11;
    localparam logic [FOLD_W-1:0]  W_BYTE3   = 13'd16;
    localparam logic [FOLD_W-1:0]  DIV25     = 13'd25;
    localparam logic [RECIP_W-1:0] RECIP_25  = 16'd41944;

    localparam logic [R400_W-1:0]  LEAP_LAST  = 9'd399;
    localparam logic [MONTH_W-1:0] MONTHS     = 4'd12;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [DAY_W-1:0]   FEB_LEAP   = 5'd29;
    localparam logic [DAY_W-1:0]   FEB_COMMON = 5'd28;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_FOLD,
        OP_MOD,
        OP_SUM,
        OP_REWIND,
        OP_WALK,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_INV,
        C_M_LT,
        C_REM_GT,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic no_req;
        logic inv;
        logic m_lt;
        logic rem_gt;
        logic out_busy;
    } t_flags;

    function automatic logic is_leap(input logic [R400_W-1:0] r400);
        logic div4;
        logic century;
        div4    = (r400[1:0] == 2'd0);
        century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
        return (div4 && !century && (r400 != '0)) || (r400 == '0);
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            FEBRUARY:                                  len = leap ? FEB_LEAP : FEB_COMMON;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/cdad_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date add days channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdad_req_if import cdad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [ADD_W-1:0]   days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface cdad_rsp_if import cdad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               year_overflow;
    logic               invalid_input;

    modport source (output valid, result_day, result_month, result_year,
                    year_overflow, invalid_input, input ready);
    modport sink   (input valid, result_day, result_month, result_year,
                    year_overflow, invalid_input, output ready);
endinterface

// ----- hw/rtl/calendar_date_add_days_top.sv -----
`timescale 1ns / 1ps
// Steps: load accepts a request, fold and mod reduce the year mod 400, sum adds the months
// before start_month, rewind adds the day count, walk steps through the months and emit
// registers the result; an invalid month goes from fold straight to emit.
// Throughput: one request at a time; emit waits while the previous result is not taken.
// Reset: synchronous active-low reset returns the step counter to the idle step
// and empties the result register.
// ----------------------------------------------------------------------------
// Calendar date add days top level
// Microcoded sequencer that adds a day count to a Gregorian date.
// ----------------------------------------------------------------------------
module calendar_date_add_days_top import cdad_pkg::*; #(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdad_req_if.sink   i_req,
    cdad_rsp_if.source o_rsp
);

    t_ctl   w_ctl;
    t_flags w_flags;

    cdad_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    cdad_datapath #(
        .YEAR_BITS (YEAR_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_flags (w_flags),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("Sequencer accepted a request while still busy.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.invalid_input) |->
        (o_rsp.result_day == '0 && o_rsp.result_month == '0 &&
         o_rsp.result_year == '0 && !o_rsp.year_overflow))
        else $error("Invalid result carries nonzero fields.");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.invalid_input) |->
        (o_rsp.result_month != '0 && o_rsp.result_month <= MONTHS))
        else $error("Result month is out of range.");

endmodule

// ----- hw/rtl/cdad_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date add days sequencer
// Step counter with the microcode table and conditional jump logic.
// ----------------------------------------------------------------------------
module cdad_sequencer import cdad_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctl   o_ctl
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctl            w_ctl;
    logic            w_jump;

    always_comb begin
        unique case (r_pc)
            3'd0:    w_ctl = '{op: OP_LOAD,   cond: C_NO_REQ,   target: 3'd0};
            3'd1:    w_ctl = '{op: OP_FOLD,   cond: C_INV,      target: 3'd6};
            3'd2:    w_ctl = '{op: OP_MOD,    cond: C_NEVER,    target: 3'd0};
            3'd3:    w_ctl = '{op: OP_SUM,    cond: C_M_LT,     target: 3'd3};
            3'd4:    w_ctl = '{op: OP_REWIND, cond: C_NEVER,    target: 3'd0};
            3'd5:    w_ctl = '{op: OP_WALK,   cond: C_REM_GT,   target: 3'd5};
            3'd6:    w_ctl = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: 3'd6};
            default: w_ctl = '{op: OP_NOP,    cond: C_ALWAYS,   target: 3'd0};
        endcase
    end

    always_comb begin
        unique case (w_ctl.cond)
            C_NEVER:    w_jump = 1'b0;
            C_ALWAYS:   w_jump = 1'b1;
            C_NO_REQ:   w_jump = i_flags.no_req;
            C_INV:      w_jump = i_flags.inv;
            C_M_LT:     w_jump = i_flags.m_lt;
            C_REM_GT:   w_jump = i_flags.rem_gt;
            C_OUT_BUSY: w_jump = i_flags.out_busy;
            default:    w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_ctl.target : r_pc + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = w_ctl;

endmodule

// ----- hw/rtl/cdad_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date add days datapath
// Day remainder, month and year registers, year mod 400 unit and result stage.
// ----------------------------------------------------------------------------
module cdad_datapath import cdad_pkg::*; #(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl       i_ctl,
    output t_flags     o_flags,
    cdad_req_if.sink   i_req,
    cdad_rsp_if.source o_rsp
);

    logic [REM_W-1:0]     r_rem,   n_rem;
    logic [MONTH_W-1:0]   r_m,     n_m;
    logic [MONTH_W-1:0]   r_month, n_month;
    logic [YEAR_BITS-1:0] r_year,  n_year;
    logic [ADD_W-1:0]     r_add,   n_add;
    logic [R400_W-1:0]    r_r400,  n_r400;
    logic [FOLD_W-1:0]    r_fold,  n_fold;
    logic                 r_ovf,   n_ovf;
    logic                 r_inv,   n_inv;

    logic                 r_out_valid, n_out_valid;
    logic [DAY_W-1:0]     r_o_day,   n_o_day;
    logic [MONTH_W-1:0]   r_o_month, n_o_month;
    logic [YEAR_W-1:0]    r_o_year,  n_o_year;
    logic                 r_o_ovf,   n_o_ovf;
    logic                 r_o_inv,   n_o_inv;

    logic [DAY_W-1:0]      w_len;
    logic [YEAR_EXT_W-1:0] w_year_ext;
    logic [FOLD_W-1:0]     w_fold;
    logic [PROD_W-1:0]     w_prod;
    logic [Q_W-1:0]        w_q;
    logic [FOLD_W-1:0]     w_r25;
    logic                  w_out_busy;
    logic                  w_accept;

    // The year mod 400 is 16 * ((year >> 4) mod 25) + year[3:0]. The shifted year
    // is folded by bytes with the weights 256^k mod 25, then reduced by a
    // reciprocal multiplication.
    assign w_len      = days_in(r_m, is_leap(r_r400));
    assign w_year_ext = YEAR_EXT_W'(r_year);
    assign w_fold     = FOLD_W'(w_year_ext[11:4])
                      + FOLD_W'(w_year_ext[19:12]) * W_BYTE1
                      + FOLD_W'(w_year_ext[27:20]) * W_BYTE2
                      + FOLD_W'(w_year_ext[31:28]) * W_BYTE3;
    assign w_prod     = PROD_W'(r_fold) * PROD_W'(RECIP_25);
    assign w_q        = w_prod[PROD_W-1:RECIP_SHIFT];
    assign w_r25      = r_fold - FOLD_W'(w_q) * DIV25;
    assign w_out_busy = r_out_valid && !o_rsp.ready;
    assign w_accept   = (i_ctl.op == OP_LOAD) && i_req.valid;

    assign o_flags.no_req   = !i_req.valid;
    assign o_flags.inv      = r_inv;
    assign o_flags.m_lt     = (r_m < r_month);
    assign o_flags.rem_gt   = (r_rem > REM_W'(w_len));
    assign o_flags.out_busy = w_out_busy;

    always_comb begin
        n_rem       = r_rem;
        n_m         = r_m;
        n_month     = r_month;
        n_year      = r_year;
        n_add       = r_add;
        n_r400      = r_r400;
        n_fold      = r_fold;
        n_ovf       = r_ovf;
        n_inv       = r_inv;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_o_day     = r_o_day;
        n_o_month   = r_o_month;
        n_o_year    = r_o_year;
        n_o_ovf     = r_o_ovf;
        n_o_inv     = r_o_inv;

        unique case (i_ctl.op)
            OP_LOAD: begin
                if (w_accept) begin
                    n_rem   = REM_W'(i_req.start_day);
                    n_m     = JANUARY;
                    n_month = i_req.start_month;
                    n_year  = YEAR_BITS'(i_req.start_year);
                    n_add   = i_req.days_to_add;
                    n_r400  = '0;
                    n_ovf   = 1'b0;
                    n_inv   = (i_req.start_month == '0) || (i_req.start_month > MONTHS);
                end
            end
            OP_FOLD: begin
                n_fold = w_fold;
            end
            OP_MOD: begin
                n_r400 = {w_r25[R25_W-1:0], r_year[3:0]};
            end
            OP_SUM: begin
                if (r_m < r_month) begin
                    n_rem = r_rem + REM_W'(w_len);
                    n_m   = r_m + 1'b1;
                end
            end
            OP_REWIND: begin
                n_rem = r_rem + REM_W'(r_add);
                n_m   = JANUARY;
            end
            OP_WALK: begin
                if (r_rem > REM_W'(w_len)) begin
                    n_rem = r_rem - REM_W'(w_len);
                    if (r_m == MONTHS) begin
                        n_m = JANUARY;
                        if (r_year == '1) begin
                            n_year = '0;
                            n_ovf  = 1'b1;
                            n_r400 = '0;
                        end else begin
                            n_year = r_year + 1'b1;
                            n_r400 = (r_r400 == LEAP_LAST) ? '0 : r_r400 + 1'b1;
                        end
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end
            end
            OP_EMIT: begin
                if (!w_out_busy) begin
                    n_out_valid = 1'b1;
                    n_o_inv     = r_inv;
                    if (r_inv) begin
                        n_o_day   = '0;
                        n_o_month = '0;
                        n_o_year  = '0;
                        n_o_ovf   = 1'b0;
                    end else begin
                        n_o_day   = r_rem[DAY_W-1:0];
                        n_o_month = r_m;
                        n_o_year  = YEAR_W'(r_year);
                        n_o_ovf   = r_ovf;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_m       <= n_m;
        r_month   <= n_month;
        r_year    <= n_year;
        r_add     <= n_add;
        r_r400    <= n_r400;
        r_fold    <= n_fold;
        r_ovf     <= n_ovf;
        r_inv     <= n_inv;
        r_o_day   <= n_o_day;
        r_o_month <= n_o_month;
        r_o_year  <= n_o_year;
        r_o_ovf   <= n_o_ovf;
        r_o_inv   <= n_o_inv;
    end

    assign i_req.ready         = (i_ctl.op == OP_LOAD);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_day    = r_o_day;
    assign o_rsp.result_month  = r_o_month;
    assign o_rsp.result_year   = r_o_year;
    assign o_rsp.year_overflow = r_o_ovf;
    assign o_rsp.invalid_input = r_o_inv;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date add days testbench
// Sends dates with day counts through the request channel and checks every
// response against a date predictor kept in the testbench. The requests are
// directed corner cases first, then random dates, with random gaps on the request
// channel and random backpressure on the response channel.
// ----------------------------------------------------------------------------
module tb;
    import cdad_pkg::*;

    localparam int WATCHDOG_CYCLES = 12000;
    localparam int RANDOM_REQUESTS = 250;
    localparam int DRAIN_CYCLES    = 64;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [ADD_W-1:0]   add;
        logic               drain_first;
    } t_date_req;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               wrapped;
        logic               invalid;
    } t_date_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdad_req_if req_ch ();
    cdad_rsp_if rsp_ch ();

    calendar_date_add_days_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    int unsigned common_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    t_date_req pending_dates [$];
    t_date_rsp expected_dates [$];

    int unsigned sent_cnt;
    int unsigned recv_cnt;
    int unsigned invalid_cnt;
    int unsigned wrap_cnt;
    int unsigned err_cnt;
    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned quiet_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_leap_year(input logic [YEAR_W-1:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m,
                                                 input logic [YEAR_W-1:0] y);
        if (m == FEBRUARY)
            return is_leap_year(y) ? FEB_LEAP : FEB_COMMON;
        return common_len[m - 1];
    endfunction

    function automatic t_date_rsp add_days_to_date(input t_date_req r);
        t_date_rsp         res;
        logic [YEAR_W-1:0] year;
        int unsigned       left;
        int unsigned       m;
        int unsigned       len;
        res = '0;
        if (r.month < JANUARY || r.month > MONTHS) begin
            res.invalid = 1'b1;
            return res;
        end
        year = r.year;
        left = r.day;
        for (m = JANUARY; m < r.month; m++)
            left += month_length(m, year);
        left += r.add;
        m = JANUARY;
        len = month_length(m, year);
        while (left > len) begin
            left -= len;
            if (m == MONTHS) begin
                m = JANUARY;
                if (year == '1)
                    res.wrapped = 1'b1;
                year = year + 1'b1;
            end else begin
                m++;
            end
            len = month_length(m, year);
        end
        res.day   = left[DAY_W-1:0];
        res.month = m[MONTH_W-1:0];
        res.year  = year;
        return res;
    endfunction

    // In every 60 requests or responses, the first 15 draw no random wait.
    function automatic int unsigned draw_wait(input int unsigned n);
        return (n % 60 < 15) ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic queue_date(input int unsigned day, input int unsigned month,
                              input int unsigned year, input int unsigned add,
                              input bit drain);
        t_date_req r;
        r.day         = day[DAY_W-1:0];
        r.month       = month[MONTH_W-1:0];
        r.year        = year[YEAR_W-1:0];
        r.add         = add[ADD_W-1:0];
        r.drain_first = drain;
        pending_dates.push_back(r);
    endtask

    function automatic void compare_field(input string name, input int unsigned exp_v,
                                          input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : request_driver
        t_date_req   cur;
        t_date_req   nxt;
        logic        busy;
        busy = req_ch.valid && !req_ch.ready;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                cur.day         = req_ch.start_day;
                cur.month       = req_ch.start_month;
                cur.year        = req_ch.start_year;
                cur.add         = req_ch.days_to_add;
                cur.drain_first = 1'b0;
                expected_dates.push_back(add_days_to_date(cur));
                sent_cnt++;
                send_gap = draw_wait(sent_cnt);
            end
            if (!busy) begin
                if (send_gap != 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_dates.size() != 0 &&
                             !(pending_dates[0].drain_first && expected_dates.size() != 0)) begin
                    nxt = pending_dates.pop_front();
                    req_ch.start_day   <= nxt.day;
                    req_ch.start_month <= nxt.month;
                    req_ch.start_year  <= nxt.year;
                    req_ch.days_to_add <= nxt.add;
                    req_ch.valid       <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_date_rsp   exp_r;
        int unsigned n;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_stall = 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            recv_cnt++;
            if (expected_dates.size() == 0) begin
                $display("%0t: response with no request outstanding, actual %0d-%0d-%0d",
                         $time, rsp_ch.result_year, rsp_ch.result_month, rsp_ch.result_day);
                err_cnt++;
            end else begin
                exp_r = expected_dates.pop_front();
                if (exp_r.invalid)
                    invalid_cnt++;
                if (exp_r.wrapped)
                    wrap_cnt++;
                compare_field("result_day", exp_r.day, rsp_ch.result_day);
                compare_field("result_month", exp_r.month, rsp_ch.result_month);
                compare_field("result_year", exp_r.year, rsp_ch.result_year);
                compare_field("year_overflow", exp_r.wrapped, rsp_ch.year_overflow);
                compare_field("invalid_input", exp_r.invalid, rsp_ch.invalid_input);
            end
            n = draw_wait(recv_cnt);
            if (n != 0) begin
                rsp_ch.ready <= 1'b0;
                recv_stall = n - 1;
            end
        end else if (!rsp_ch.ready) begin
            if (recv_stall == 0)
                rsp_ch.ready <= 1'b1;
            else
                recv_stall--;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: no request or response moved for %0d cycles",
                         $time, WATCHDOG_CYCLES);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned add;
        int unsigned pick;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.start_day   = '0;
        req_ch.start_month = '0;
        req_ch.start_year  = '0;
        req_ch.days_to_add = '0;
        rsp_ch.ready       = 1'b0;

        queue_date(1, JANUARY, 2000, 0, 0);
        queue_date(0, JANUARY, 2023, 0, 0);
        queue_date(0, 7, 2023, 0, 0);
        queue_date(28, FEBRUARY, 1900, 1, 0);
        queue_date(28, FEBRUARY, 2000, 1, 0);
        queue_date(28, FEBRUARY, 2024, 1, 0);
        queue_date(28, FEBRUARY, 2023, 1, 0);
        queue_date(28, FEBRUARY, 0, 1, 0);
        queue_date(31, FEBRUARY, 2021, 0, 0);
        queue_date(31, MONTHS, 2023, 0, 0);
        queue_date(31, MONTHS, 2023, 1, 0);
        queue_date(31, MONTHS, 65535, 0, 0);
        queue_date(31, MONTHS, 65535, 1, 0);
        queue_date(31, MONTHS, 65535, 65535, 0);
        queue_date(1, JANUARY, 0, 65535, 0);
        queue_date(31, MONTHS, 65400, 65535, 0);
        queue_date(15, 0, 2023, 10, 0);
        queue_date(31, 13, 65535, 65535, 0);
        queue_date(1, 14, 0, 0, 0);
        queue_date(31, 15, 2023, 100, 0);
        queue_date(29, FEBRUARY, 2100, 365, 0);
        queue_date(30, 11, 1999, 31, 0);

        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
                month = $urandom_range(JANUARY, MONTHS);
            else
                month = (pick < 91) ? 0 : $urandom_range(13, 15);
            day = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                year = $urandom_range(0, 65535);
            else if (pick < 70)
                year = $urandom_range(1582, 2500);
            else if (pick < 85)
                year = $urandom_range(65400, 65535);
            else
                year = $urandom_range(0, 163) * 400 + $urandom_range(0, 3) * 100;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                add = $urandom_range(0, 400);
            else if (pick < 85)
                add = $urandom_range(0, 6000);
            else
                add = $urandom_range(0, 65535);
            queue_date(day, month, year, add, (i % 90) == 0);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_dates.size() != 0 || req_ch.valid || expected_dates.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d dates and checked %0d responses with random gaps and stalls.",
                 sent_cnt, recv_cnt);
        $display("Responses included %0d invalid months and %0d year wraps.",
                 invalid_cnt, wrap_cnt);
        if (err_cnt == 0 && expected_dates.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cdad_pkg.sv
hw/rtl/cdad_if.sv
hw/rtl/cdad_sequencer.sv
hw/rtl/cdad_datapath.sv
hw/rtl/calendar_date_add_days_top.sv
sim/tb.sv
